### hw/rtl/wse_pkg.sv
// ----------------------------------------------------------------------------
// WS2812 SPI encoder package
// Shared constants, register indexes, command codes and the channel scaling function.
// ----------------------------------------------------------------------------
package wse_pkg;

	localparam int RESET_BYTES_DEF = 7;
	localparam int PIXEL_BYTES     = 24;
	localparam int MAX_RESULTS     = 24;
	localparam int CNT_W           = $clog2(MAX_RESULTS);

	localparam logic [7:0] BRIGHTNESS_RST = 8'd255;
	localparam logic [7:0] ONE_CODE_RST   = 8'd248;
	localparam logic [7:0] ZERO_CODE_RST  = 8'd192;
	localparam logic [7:0] RESET_CODE_RST = 8'd0;

	typedef enum logic [1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_ONE_CODE   = 2'd1,
		REG_ZERO_CODE  = 2'd2,
		REG_RESET_CODE = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_RESET = 1'b1
	} cmd_t;

	function automatic logic [7:0] scale_chan(input logic [7:0] gain, input logic [7:0] chan);
		logic [15:0] prod;
		prod = ({8'd0, gain} * {8'd0, chan}) + 16'd1;
		return prod[15:8];
	endfunction

endpackage

### hw/rtl/ws2812_spi_pixel_encoder.sv
// ----------------------------------------------------------------------------
// WS2812 SPI pixel encoder
// Scales one RGB pixel by the brightness register and expands every data bit
// into one SPI byte, or emits the latch reset gap on request.
// ----------------------------------------------------------------------------
//  Channel    | Handshake                | Payload
//  -----------+--------------------------+------------------------------------
//  pixel      | pixel_valid, pixel_stall | command, red, green, blue
//  spi        | spi_valid, spi_stall     | spi_byte, last
//  config     | cfg_write                | cfg_index, cfg_data
//
// A pixel gives 24 bytes and a reset request gives RESET_BYTES bytes (capped at
// 24), one byte per cycle from the output register while spi_stall stays low.
// The byte serializer sets the rate.
// An item waits in the input register while the previous one is serialized.
// A stall on the spi side holds the output byte and backs up to pixel_stall.
// Reset clears all valid state and loads the register defaults.
// ----------------------------------------------------------------------------
module ws2812_spi_pixel_encoder #(
	parameter int RESET_BYTES = wse_pkg::RESET_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  logic       command,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       spi_valid,
	input  logic       spi_stall,
	output logic [7:0] spi_byte,
	output logic       last
);
	import wse_pkg::*;

	localparam int RESET_LEN = (RESET_BYTES > MAX_RESULTS) ? MAX_RESULTS :
	                           ((RESET_BYTES < 1) ? 1 : RESET_BYTES);
	localparam logic [CNT_W-1:0] PIX_LAST = CNT_W'(PIXEL_BYTES - 1);
	localparam logic [CNT_W-1:0] RST_LAST = CNT_W'(RESET_LEN - 1);

	logic [7:0] brightness_q;
	logic [7:0] one_code_q;
	logic [7:0] zero_code_q;
	logic [7:0] reset_code_q;

	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] red_s1;
	logic [7:0] green_s1;
	logic [7:0] blue_s1;

	logic             busy_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PIXEL_BYTES-1:0] bits_q;

	logic       out_valid_q;
	logic [7:0] spi_byte_q;
	logic       last_q;

	logic out_adv;
	logic emit;
	logic ser_last;
	logic load;
	logic take_in;
	logic [PIXEL_BYTES-1:0] scaled;

	assign out_adv  = !out_valid_q || !spi_stall;
	assign emit     = busy_q && out_adv;
	assign ser_last = (cnt_q == ((cmd_q == CMD_RESET) ? RST_LAST : PIX_LAST));
	assign load     = valid_s1 && (!busy_q || (emit && ser_last));
	assign pixel_stall = valid_s1 && !load;
	assign take_in  = pixel_valid && !pixel_stall;

	assign scaled = {scale_chan(brightness_q, green_s1),
	                 scale_chan(brightness_q, red_s1),
	                 scale_chan(brightness_q, blue_s1)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHTNESS_RST;
			one_code_q   <= ONE_CODE_RST;
			zero_code_q  <= ZERO_CODE_RST;
			reset_code_q <= RESET_CODE_RST;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BRIGHTNESS: brightness_q <= cfg_data;
				REG_ONE_CODE:   one_code_q   <= cfg_data;
				REG_ZERO_CODE:  zero_code_q  <= cfg_data;
				REG_RESET_CODE: reset_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				out_valid_q <= busy_q;
			end
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
				if (ser_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1   <= cmd_t'(command);
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
		if (emit) begin
			spi_byte_q <= (cmd_q == CMD_RESET) ? reset_code_q :
			              (bits_q[PIXEL_BYTES-1] ? one_code_q : zero_code_q);
			last_q     <= ser_last;
		end
		if (load) begin
			cmd_q  <= cmd_s1;
			bits_q <= scaled;
		end else if (emit) begin
			bits_q <= {bits_q[PIXEL_BYTES-2:0], 1'b0};
		end
	end

	assign spi_valid = out_valid_q;
	assign spi_byte  = spi_byte_q;
	assign last      = last_q;

endmodule

### hw/rtl/wse_checker.sv
// ----------------------------------------------------------------------------
// WS2812 SPI encoder port checker
// Watches the top-level handshakes for byte count and flow consistency.
// ----------------------------------------------------------------------------
module wse_checker (
	input logic clk,
	input logic arst_n,
	input logic pixel_valid,
	input logic pixel_stall,
	input logic spi_valid,
	input logic spi_stall,
	input logic [7:0] spi_byte,
	input logic last
);
	import wse_pkg::*;

	logic [CNT_W-1:0] bytes_q;
	logic [2:0]       pend_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = pixel_valid && !pixel_stall;
	assign out_acc = spi_valid && !spi_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			pend_q  <= '0;
		end else begin
			if (out_acc) begin
				bytes_q <= last ? '0 : bytes_q + 1'b1;
			end
			pend_q <= pend_q + {2'd0, in_acc} - {2'd0, out_acc && last};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		spi_valid && spi_stall |=> spi_valid && $stable(spi_byte) && $stable(last))
		else $error("stalled spi byte changed");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !last |-> bytes_q != CNT_W'(MAX_RESULTS - 1))
		else $error("request produced more than the maximum number of bytes");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		spi_valid |-> pend_q != 3'd0)
		else $error("spi byte shown with no request pending");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd0 |-> !pixel_stall)
		else $error("encoder stalls input while empty");

endmodule

bind ws2812_spi_pixel_encoder wse_checker u_wse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_stall (pixel_stall),
	.spi_valid   (spi_valid),
	.spi_stall   (spi_stall),
	.spi_byte    (spi_byte),
	.last        (last)
);

### bench/tb_ws2812_spi_pixel_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WS2812 SPI pixel encoder testbench
// Feeds pixel and reset-gap requests through the valid/stall handshake and
// checks every SPI byte and its last flag against an encoder model kept here.
// The run walks through several register settings, including the extremes, and
// changes how often each side idles. In one phase the SPI side holds off for a
// long stretch, so the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_ws2812_spi_pixel_encoder;
	import wse_pkg::*;

	localparam int GAP_BYTES      = RESET_BYTES_DEF;
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_LIMIT    = 100;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_req_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       last;
	} spi_beat_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_write   = 1'b0;
	logic [1:0] cfg_index   = '0;
	logic [7:0] cfg_data    = '0;
	logic       pixel_valid = 1'b0;
	logic       pixel_stall;
	logic       command     = 1'b0;
	logic [7:0] red         = '0;
	logic [7:0] green       = '0;
	logic [7:0] blue        = '0;
	logic       spi_valid;
	logic       spi_stall   = 1'b0;
	logic [7:0] spi_byte;
	logic       last;

	pix_req_t  pixel_requests[$];
	spi_beat_t spi_expected[$];
	pix_req_t  offered;
	spi_beat_t next_beat;

	logic [7:0] gain;
	logic [7:0] one_pat;
	logic [7:0] zero_pat;
	logic [7:0] gap_pat;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_arm      = 1'b0;
	bit hold_done;
	int hold_left;
	int idle_cycles;
	int mismatch_count = 0;

	ws2812_spi_pixel_encoder #(
		.RESET_BYTES(GAP_BYTES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.command    (command),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.spi_valid  (spi_valid),
		.spi_stall  (spi_stall),
		.spi_byte   (spi_byte),
		.last       (last)
	);

	always #6 clk = ~clk;

	function automatic logic [7:0] apply_gain(logic [7:0] level);
		int unsigned prod;
		prod = int'(gain) * int'(level) + 1;
		return 8'(prod >> 8);
	endfunction

	function automatic void encode_request(pix_req_t req);
		logic [7:0] chan [3];
		int         n;
		if (req.command == CMD_RESET) begin
			n = (GAP_BYTES > MAX_RESULTS) ? MAX_RESULTS : ((GAP_BYTES < 1) ? 1 : GAP_BYTES);
			for (int i = 0; i < n; i++)
				spi_expected.push_back('{gap_pat, (i == n - 1)});
		end else begin
			chan[0] = apply_gain(req.green);
			chan[1] = apply_gain(req.red);
			chan[2] = apply_gain(req.blue);
			for (int c = 0; c < 3; c++)
				for (int b = 7; b >= 0; b--)
					spi_expected.push_back('{chan[c][b] ? one_pat : zero_pat,
						(c == 2 && b == 0)});
		end
	endfunction

	task automatic report_mismatch(string what);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_BRIGHTNESS: gain     = value;
			REG_ONE_CODE:   one_pat  = value;
			REG_ZERO_CODE:  zero_pat = value;
			REG_RESET_CODE: gap_pat  = value;
		endcase
	endtask

	task automatic queue_pixel(cmd_t cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_requests.push_back('{cmd, r, g, b});
	endtask

	function automatic logic [7:0] random_level();
		case ($urandom_range(9, 0))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++)
			queue_pixel(($urandom_range(99, 0) < 15) ? CMD_RESET : CMD_PIXEL,
				random_level(), random_level(), random_level());
	endtask

	task automatic drain();
		while (pixel_requests.size() != 0 || pixel_valid || spi_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Request driver: a new request is offered only once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			command     <= CMD_PIXEL;
			red         <= '0;
			green       <= '0;
			blue        <= '0;
		end else begin
			if (pixel_valid && !pixel_stall)
				encode_request(offered);
			if (!pixel_valid || !pixel_stall) begin
				if (pixel_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					offered = pixel_requests.pop_front();
					pixel_valid <= 1'b1;
					command     <= offered.command;
					red         <= offered.red;
					green       <= offered.green;
					blue        <= offered.blue;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// SPI monitor and stall generator.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spi_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (spi_valid && !spi_stall) begin
				if (spi_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %h last %b", spi_byte, last));
				end else begin
					next_beat = spi_expected.pop_front();
					if (spi_byte !== next_beat.spi_byte)
						report_mismatch($sformatf("spi_byte %h, expected %h",
							spi_byte, next_beat.spi_byte));
					if (last !== next_beat.last)
						report_mismatch($sformatf("last %b, expected %b",
							last, next_beat.last));
				end
			end
			if (hold_arm && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				spi_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				spi_stall <= 1'b1;
			end else begin
				spi_stall <= ($urandom_range(99, 0) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((pixel_valid && !pixel_stall) || (spi_valid && !spi_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		gain     = BRIGHTNESS_RST;
		one_pat  = ONE_CODE_RST;
		zero_pat = ZERO_CODE_RST;
		gap_pat  = RESET_CODE_RST;
		send_idle_pct = 28;
		recv_idle_pct = 81;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests under the reset defaults.
		queue_pixel(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
		queue_pixel(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		queue_pixel(CMD_PIXEL, 8'hFF, 8'h00, 8'h00);
		queue_pixel(CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
		queue_pixel(CMD_PIXEL, 8'h00, 8'h00, 8'hFF);
		queue_pixel(CMD_RESET, 8'h00, 8'h00, 8'h00);
		queue_pixel(CMD_RESET, 8'hFF, 8'hFF, 8'hFF);
		queue_pixel(CMD_PIXEL, 8'h80, 8'h01, 8'hAA);
		queue_pixel(CMD_PIXEL, 8'h55, 8'hAA, 8'h01);
		queue_pixel(CMD_PIXEL, 8'h01, 8'h02, 8'h80);
		queue_pixel(CMD_PIXEL, 8'h7F, 8'hFE, 8'h81);
		queue_pixel(CMD_RESET, 8'hA5, 8'h5A, 8'h3C);
		queue_pixel(CMD_RESET, 8'h00, 8'hFF, 8'h00);
		queue_pixel(CMD_PIXEL, 8'hC3, 8'h3C, 8'h99);
		queue_pixel(CMD_PIXEL, 8'h10, 8'h20, 8'h40);
		queue_pixel(CMD_PIXEL, 8'hFE, 8'h7F, 8'h01);
		drain();

		// Extreme codes and zero brightness: every channel scales to zero.
		write_reg(REG_BRIGHTNESS, 8'h00);
		write_reg(REG_ONE_CODE,   8'hFF);
		write_reg(REG_ZERO_CODE,  8'h00);
		write_reg(REG_RESET_CODE, 8'hFF);
		queue_pixel(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		queue_random(50);
		drain();

		send_idle_pct = 81;
		recv_idle_pct = 28;
		write_reg(REG_BRIGHTNESS, 8'($urandom_range(254, 2)));
		write_reg(REG_ONE_CODE,   8'($urandom));
		write_reg(REG_ZERO_CODE,  8'($urandom));
		write_reg(REG_RESET_CODE, 8'($urandom));
		queue_random(70);
		drain();

		// Full brightness with inverted codes, and a long hold on the SPI side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_BRIGHTNESS, 8'hFF);
		write_reg(REG_ONE_CODE,   8'h00);
		write_reg(REG_ZERO_CODE,  8'hFF);
		write_reg(REG_RESET_CODE, 8'($urandom));
		hold_arm = 1'b1;
		queue_random(70);
		drain();

		write_reg(REG_BRIGHTNESS, 8'h01);
		write_reg(REG_ONE_CODE,   8'($urandom));
		write_reg(REG_ZERO_CODE,  8'($urandom));
		write_reg(REG_RESET_CODE, 8'h00);
		queue_pixel(CMD_PIXEL, 8'hFF, 8'hFE, 8'hFF);
		queue_random(60);
		drain();

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
